// ===== design/qcc_pkg.sv =====
package qcc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_CHANNELS    = 3;
  localparam int DEF_COUNT_WIDTH = 32;

  // Command codes
  localparam logic [7:0] CMD_READ    = 8'h05;
  localparam logic [7:0] CMD_ECHO    = 8'h06;
  localparam logic [7:0] CMD_CLEAR   = 8'h07;
  localparam logic [7:0] CMD_RESTART = 8'h08;

  // Reply bytes
  localparam logic [7:0] FRAME_START   = 8'd170;
  localparam logic [7:0] FRAME_END     = 8'd169;
  localparam logic [7:0] REPLY_UNKNOWN = 8'hFF;

  // Counter value after reset, cut to the counter width at use
  localparam logic [63:0] RESET_PATTERN = 64'h0000_0000_CCCC_CCCC;

  // Input item kinds
  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

endpackage

// ===== design/quadrature_counter_command_port.sv =====
// An edge transaction updates its counter at the accepting clock edge; a reply's first
//   byte is registered once busy is set and the output is free. One input transaction per
//   cycle while in_ready is high; a read frame leaves at one byte per cycle while out_ready
//   is high; a command with a reply waits until the current reply's last byte is loaded.
// Reset (rst_n, synchronous, active low): counters load 0xCCCCCCCC, reply logic goes idle.
module quadrature_counter_command_port #(
  parameter int CHANNELS    = qcc_pkg::DEF_CHANNELS,
  parameter int COUNT_WIDTH = qcc_pkg::DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [1:0] in_channel,
  input  logic       in_edge_on_b,
  input  logic       in_level_a,
  input  logic       in_level_b,
  input  logic [7:0] in_command,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_last
);
  import qcc_pkg::*;

  // Frame layout: start byte, COUNT_BYTES per channel (LSB first), end byte
  localparam int COUNT_BYTES = (COUNT_WIDTH + 7) / 8;
  localparam int SNAP_W      = CHANNELS * COUNT_BYTES * 8;
  localparam int TOTAL       = CHANNELS * COUNT_BYTES + 2;
  localparam int CNT_W       = $clog2(TOTAL + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // ---------------------------------------------------------------------------
  // Handshake
  // A command that answers can only start when the reply sequencer is free,
  // or in the cycle its last byte moves into the output register.
  // Edges, clear and restart never produce bytes and are always taken.
  // ---------------------------------------------------------------------------
  logic busy_r;
  logic in_fire;
  logic silent_cmd;
  logic seq_done;

  assign silent_cmd = (in_command == CMD_CLEAR) || (in_command == CMD_RESTART);
  assign in_ready   = !busy_r || seq_done || (in_mode == MODE_EDGE) || silent_cmd;
  assign in_fire    = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Position counters
  // A edge: down when A == B. B edge: down when A != B.
  // ---------------------------------------------------------------------------
  count_t count_r   [CHANNELS];
  count_t count_nxt [CHANNELS];
  logic   down;

  assign down = in_edge_on_b ^ (in_level_a == in_level_b);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i] = count_r[i];
      if (in_fire && (in_mode == MODE_EDGE) && (32'(in_channel) == i)) begin
        count_nxt[i] = down ? count_r[i] - 1'b1 : count_r[i] + 1'b1;
      end
      if (in_fire && (in_mode == MODE_COMMAND) && (in_command == CMD_CLEAR)) begin
        count_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= COUNT_WIDTH'(RESET_PATTERN);
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // Read snapshots every counter so later edges do not disturb the frame.
  // ---------------------------------------------------------------------------
  logic             start_read;
  logic             start_single;
  logic [7:0]       single_byte;
  logic [SNAP_W-1:0] snapshot;

  always_comb begin
    start_read   = 1'b0;
    start_single = 1'b0;
    single_byte  = REPLY_UNKNOWN;
    if (in_fire && (in_mode == MODE_COMMAND)) begin
      case (in_command)
        CMD_READ:    start_read = 1'b1;
        CMD_ECHO: begin
          start_single = 1'b1;
          single_byte  = CMD_ECHO;
        end
        CMD_CLEAR:   ;
        CMD_RESTART: ;
        default: begin
          start_single = 1'b1;
          single_byte  = REPLY_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      snapshot[i*COUNT_BYTES*8 +: COUNT_BYTES*8] = (COUNT_BYTES*8)'(count_r[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Reply sequencer and output register
  // cnt_r counts bytes still to send; snap_r shifts one byte per counter byte.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_r;
  logic              is_read_r;
  logic [7:0]        single_r;
  logic [SNAP_W-1:0] snap_r;
  logic              out_valid_r;
  logic [7:0]        out_data_byte_r;
  logic              out_last_r;

  logic              load;
  logic [7:0]        byte_nxt;
  logic              last_nxt;
  logic              at_start;
  logic              at_end;

  assign load     = busy_r && (!out_valid_r || out_ready);
  assign at_start = (cnt_r == CNT_W'(TOTAL));
  assign at_end   = (cnt_r == CNT_W'(1));
  assign seq_done = load && at_end;

  always_comb begin
    last_nxt = at_end;
    if (!is_read_r) begin
      byte_nxt = single_r;
      last_nxt = 1'b1;
    end else if (at_start) begin
      byte_nxt = FRAME_START;
    end else if (at_end) begin
      byte_nxt = FRAME_END;
    end else begin
      byte_nxt = snap_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (start_read || start_single) begin
        busy_r <= 1'b1;
      end else if (seq_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Payload, no reset needed; a new reply start overrides the last-byte step
  always_ff @(posedge clk) begin
    if (start_read || start_single) begin
      cnt_r     <= start_read ? CNT_W'(TOTAL) : CNT_W'(1);
      is_read_r <= start_read;
      single_r  <= single_byte;
      snap_r    <= snapshot;
    end else if (load) begin
      cnt_r <= cnt_r - 1'b1;
      if (is_read_r && !at_start && !at_end) begin
        snap_r <= snap_r >> 8;
      end
    end
    if (load) begin
      out_data_byte_r <= byte_nxt;
      out_last_r      <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_byte_r;
  assign out_last      = out_last_r;

endmodule
